>>> rtl/core/blfv_pkg.sv
// ----------------------------------------------------------------------------
// blfv_pkg
// Shared types and constants of the Lorentz boost block: item layouts,
// coefficient set, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package blfv_pkg;

  localparam int unsigned FieldW       = 32;
  localparam int unsigned BetaW        = 31;
  localparam int unsigned CoefW        = 62;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned FifoDepthDef = 2;

  // iteration counts of the coefficient engine
  localparam int unsigned MulSteps  = 64;
  localparam int unsigned DivSteps  = 128;
  localparam int unsigned RootSteps = 32;
  localparam int unsigned CntW      = 7;

  localparam logic [63:0] OneQ30       = 64'h0000_0000_4000_0000;
  localparam logic [63:0] OneQ60       = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HalfQ29      = 64'h0000_0000_2000_0000;
  localparam logic [63:0] SlowLimitQ60 = 64'd11529215046068;
  localparam logic [63:0] RootBitInit  = 64'h4000_0000_0000_0000;

  localparam logic [FieldW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [FieldW-1:0] SatMin = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BETA_X = 2'd0,
    CFG_BETA_Y = 2'd1,
    CFG_BETA_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [FieldW-1:0] time_in;
    logic signed [FieldW-1:0] pos_x_in;
    logic signed [FieldW-1:0] pos_y_in;
    logic signed [FieldW-1:0] pos_z_in;
    logic signed [FieldW-1:0] energy_in;
    logic signed [FieldW-1:0] mom_x_in;
    logic signed [FieldW-1:0] mom_y_in;
    logic signed [FieldW-1:0] mom_z_in;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldW-1:0] time_out;
    logic signed [FieldW-1:0] pos_x_out;
    logic signed [FieldW-1:0] pos_y_out;
    logic signed [FieldW-1:0] pos_z_out;
    logic signed [FieldW-1:0] energy_out;
    logic signed [FieldW-1:0] mom_x_out;
    logic signed [FieldW-1:0] mom_y_out;
    logic signed [FieldW-1:0] mom_z_out;
    logic                     bad_speed;
  } out_item_t;

  // queued item: payload plus the tag set at acceptance
  typedef struct packed {
    in_item_t data;
    logic     bad;
  } queue_item_t;

  // unique entries of the symmetric boost matrix, two's complement Q.30
  typedef struct packed {
    logic signed [CoefW-1:0] l00;
    logic signed [CoefW-1:0] l01;
    logic signed [CoefW-1:0] l02;
    logic signed [CoefW-1:0] l03;
    logic signed [CoefW-1:0] l11;
    logic signed [CoefW-1:0] l22;
    logic signed [CoefW-1:0] l33;
    logic signed [CoefW-1:0] l12;
    logic signed [CoefW-1:0] l13;
    logic signed [CoefW-1:0] l23;
    logic                    bad;
  } coef_t;

  localparam coef_t CoefIdentity = '{
    l00: CoefW'(OneQ30), l01: '0, l02: '0, l03: '0,
    l11: CoefW'(OneQ30), l22: CoefW'(OneQ30), l33: CoefW'(OneQ30),
    l12: '0, l13: '0, l23: '0, bad: 1'b0
  };

endpackage

>>> rtl/core/blfv_stream_if.sv
// ----------------------------------------------------------------------------
// blfv_stream_if
// Valid/ready stream channel carrying one item payload.
// ----------------------------------------------------------------------------
interface blfv_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/blfv_front.sv
// ----------------------------------------------------------------------------
// blfv_front
// Holds the velocity registers, derives the boost matrix with a shared
// serial multiply / divide / square-root engine, and accepts and tags items.
// ----------------------------------------------------------------------------
module blfv_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [blfv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [blfv_pkg::BetaW-1:0]    cfg_wdata_i,
  blfv_stream_if.sink                   in_i,
  input  logic                          full_i,
  output logic                          push_o,
  output blfv_pkg::queue_item_t         push_item_o,
  output blfv_pkg::coef_t               coef_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_START = 9'b0_0000_0010,
    ST_SQ    = 9'b0_0000_0100,
    ST_SUM   = 9'b0_0000_1000,
    ST_ROOT  = 9'b0_0001_0000,
    ST_GAMMA = 9'b0_0010_0000,
    ST_ROW0  = 9'b0_0100_0000,
    ST_CMUL  = 9'b0_1000_0000,
    ST_CDIV  = 9'b1_0000_0000
  } state_e;

  localparam int unsigned CW = blfv_pkg::CntW;

  state_e                           state_q, state_d;
  logic [blfv_pkg::BetaW-1:0]       beta_q [3];
  logic [CW-1:0]                    cnt_q, cnt_d;
  logic [2:0]                       idx_q, idx_d;
  logic [127:0]                     wk_q, wk_d;
  logic [63:0]                      rem_q, rem_d;
  logic [63:0]                      opnd_q, opnd_d;
  logic [60:0]                      prod_q [6];
  logic [60:0]                      prod_d [6];
  logic [61:0]                      b2_q, b2_d;
  logic [60:0]                      gamma_q, gamma_d;
  blfv_pkg::coef_t                  coef_q, coef_d;

  logic                             neg_x, neg_y, neg_z;
  logic [blfv_pkg::BetaW-1:0]       mag_x, mag_y, mag_z;
  logic                             cfg_hit;

  // engine step results
  logic [64:0]                      mul_sum;
  logic [127:0]                     mul_next;
  logic [64:0]                      div_r;
  logic                             div_ge;
  logic [63:0]                      div_rem_n;
  logic [127:0]                     div_wk_n;
  logic [63:0]                      root_t;
  logic                             root_ge;
  logic [63:0]                      root_rem_n;
  logic [63:0]                      root_res_n;
  logic [63:0]                      g1;

  // axis of the first and second factor of product p
  function automatic logic [1:0] axis_a(input logic [2:0] p);
    case (p)
      3'd1:    return 2'd1;
      3'd2:    return 2'd2;
      3'd5:    return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] axis_b(input logic [2:0] p);
    case (p)
      3'd1, 3'd3: return 2'd1;
      3'd2, 3'd4,
      3'd5:       return 2'd2;
      default:    return 2'd0;
    endcase
  endfunction

  function automatic logic [blfv_pkg::BetaW-1:0] sel3(
    input logic [1:0]                 ax,
    input logic [blfv_pkg::BetaW-1:0] m0,
    input logic [blfv_pkg::BetaW-1:0] m1,
    input logic [blfv_pkg::BetaW-1:0] m2
  );
    case (ax)
      2'd1:    return m1;
      2'd2:    return m2;
      default: return m0;
    endcase
  endfunction

  function automatic logic signed [blfv_pkg::CoefW-1:0] apply_sign(
    input logic [63:0] mag,
    input logic        neg
  );
    logic [blfv_pkg::CoefW-1:0] m;
    m = mag[blfv_pkg::CoefW-1:0];
    return neg ? $signed(~m + 1'b1) : $signed(m);
  endfunction

  // velocity magnitudes and signs
  assign neg_x = beta_q[0][blfv_pkg::BetaW-1];
  assign neg_y = beta_q[1][blfv_pkg::BetaW-1];
  assign neg_z = beta_q[2][blfv_pkg::BetaW-1];
  assign mag_x = neg_x ? (~beta_q[0] + 1'b1) : beta_q[0];
  assign mag_y = neg_y ? (~beta_q[1] + 1'b1) : beta_q[1];
  assign mag_z = neg_z ? (~beta_q[2] + 1'b1) : beta_q[2];

  assign cfg_hit = cfg_we_i && (cfg_idx_i == blfv_pkg::CFG_BETA_X ||
                                cfg_idx_i == blfv_pkg::CFG_BETA_Y ||
                                cfg_idx_i == blfv_pkg::CFG_BETA_Z);

  // one shift-add multiply step
  assign mul_sum  = {1'b0, wk_q[127:64]} + (wk_q[0] ? {1'b0, opnd_q} : 65'd0);
  assign mul_next = {mul_sum, wk_q[63:1]};

  // one restoring divide step
  assign div_r     = {rem_q, wk_q[127]};
  assign div_ge    = div_r >= {1'b0, opnd_q};
  assign div_rem_n = div_ge ? 64'(div_r - {1'b0, opnd_q}) : div_r[63:0];
  assign div_wk_n  = {wk_q[126:0], div_ge};

  // one digit of the integer square root
  assign root_t     = wk_q[63:0] + opnd_q;
  assign root_ge    = rem_q >= root_t;
  assign root_rem_n = root_ge ? rem_q - root_t : rem_q;
  assign root_res_n = root_ge ? (wk_q[63:0] >> 1) + opnd_q : (wk_q[63:0] >> 1);

  assign g1 = {3'd0, gamma_q} - blfv_pkg::OneQ30;

  // coefficient sequencer
  always_comb begin
    logic [61:0] sum;
    logic [63:0] s_val;
    logic [127:0] w;
    logic [63:0] q;
    logic [2:0] nx;
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q + CW'(1);
    wk_d    = wk_q;
    rem_d   = rem_q;
    opnd_d  = opnd_q;
    prod_d  = prod_q;
    b2_d    = b2_q;
    gamma_d = gamma_q;
    coef_d  = coef_q;
    sum     = 62'(prod_q[0]) + 62'(prod_q[1]) + 62'(prod_q[2]);
    s_val   = (root_res_n == 64'd0) ? 64'd1 : root_res_n;
    w       = mul_next + {64'd0, blfv_pkg::HalfQ29};
    q       = div_wk_n[63:0];
    nx      = idx_q + 3'd1;

    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
      end
      ST_START: begin
        idx_d   = 3'd0;
        cnt_d   = '0;
        opnd_d  = 64'(sel3(axis_a(3'd0), mag_x, mag_y, mag_z));
        wk_d    = {64'd0, 64'(sel3(axis_b(3'd0), mag_x, mag_y, mag_z))};
        state_d = ST_SQ;
      end
      ST_SQ: begin
        wk_d = mul_next;
        if (cnt_q == CW'(blfv_pkg::MulSteps - 1)) begin
          prod_d[idx_q] = mul_next[60:0];
          cnt_d = '0;
          if (idx_q == 3'd5) begin
            state_d = ST_SUM;
          end else begin
            idx_d  = nx;
            opnd_d = 64'(sel3(axis_a(nx), mag_x, mag_y, mag_z));
            wk_d   = {64'd0, 64'(sel3(axis_b(nx), mag_x, mag_y, mag_z))};
          end
        end
      end
      ST_SUM: begin
        b2_d  = sum;
        cnt_d = '0;
        if (64'(sum) <= blfv_pkg::SlowLimitQ60 || 64'(sum) >= blfv_pkg::OneQ60) begin
          coef_d     = blfv_pkg::CoefIdentity;
          coef_d.bad = 64'(sum) >= blfv_pkg::OneQ60;
          state_d    = ST_IDLE;
        end else begin
          rem_d   = blfv_pkg::OneQ60 - 64'(sum);
          wk_d    = '0;
          opnd_d  = blfv_pkg::RootBitInit;
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        rem_d  = root_rem_n;
        wk_d   = {64'd0, root_res_n};
        opnd_d = opnd_q >> 2;
        if (cnt_q == CW'(blfv_pkg::RootSteps - 1)) begin
          // gamma = 2^60 / s
          wk_d    = {64'd0, blfv_pkg::OneQ60};
          rem_d   = '0;
          opnd_d  = s_val;
          cnt_d   = '0;
          state_d = ST_GAMMA;
        end
      end
      ST_GAMMA: begin
        wk_d  = div_wk_n;
        rem_d = div_rem_n;
        if (cnt_q == CW'(blfv_pkg::DivSteps - 1)) begin
          gamma_d    = div_wk_n[60:0];
          coef_d.l00 = apply_sign({3'd0, div_wk_n[60:0]}, 1'b0);
          idx_d      = 3'd0;
          cnt_d      = '0;
          opnd_d     = {3'd0, div_wk_n[60:0]};
          wk_d       = {64'd0, 64'(mag_x)};
          state_d    = ST_ROW0;
        end
      end
      ST_ROW0: begin
        wk_d = mul_next;
        if (cnt_q == CW'(blfv_pkg::MulSteps - 1)) begin
          cnt_d = '0;
          case (idx_q)
            3'd0:    coef_d.l01 = apply_sign(w[93:30], !neg_x);
            3'd1:    coef_d.l02 = apply_sign(w[93:30], !neg_y);
            default: coef_d.l03 = apply_sign(w[93:30], !neg_z);
          endcase
          if (idx_q == 3'd2) begin
            idx_d   = 3'd0;
            opnd_d  = g1;
            wk_d    = {64'd0, 64'(prod_q[0])};
            state_d = ST_CMUL;
          end else begin
            idx_d  = nx;
            opnd_d = {3'd0, gamma_q};
            wk_d   = {64'd0, 64'(sel3(nx[1:0], mag_x, mag_y, mag_z))};
          end
        end
      end
      ST_CMUL: begin
        wk_d = mul_next;
        if (cnt_q == CW'(blfv_pkg::MulSteps - 1)) begin
          rem_d   = '0;
          opnd_d  = 64'(b2_q);
          cnt_d   = '0;
          state_d = ST_CDIV;
        end
      end
      ST_CDIV: begin
        wk_d  = div_wk_n;
        rem_d = div_rem_n;
        if (cnt_q == CW'(blfv_pkg::DivSteps - 1)) begin
          cnt_d = '0;
          case (idx_q)
            3'd0:    coef_d.l11 = apply_sign(blfv_pkg::OneQ30 + q, 1'b0);
            3'd1:    coef_d.l22 = apply_sign(blfv_pkg::OneQ30 + q, 1'b0);
            3'd2:    coef_d.l33 = apply_sign(blfv_pkg::OneQ30 + q, 1'b0);
            3'd3:    coef_d.l12 = apply_sign(q, neg_x ^ neg_y);
            3'd4:    coef_d.l13 = apply_sign(q, neg_x ^ neg_z);
            default: coef_d.l23 = apply_sign(q, neg_y ^ neg_z);
          endcase
          if (idx_q == 3'd5) begin
            coef_d.bad = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            idx_d   = nx;
            opnd_d  = g1;
            wk_d    = {64'd0, 64'(prod_q[nx])};
            state_d = ST_CMUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a register write restarts the derivation
    if (cfg_hit) begin
      state_d = ST_START;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      coef_q    <= blfv_pkg::CoefIdentity;
      beta_q[0] <= '0;
      beta_q[1] <= '0;
      beta_q[2] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      coef_q  <= coef_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          blfv_pkg::CFG_BETA_X: beta_q[0] <= cfg_wdata_i;
          blfv_pkg::CFG_BETA_Y: beta_q[1] <= cfg_wdata_i;
          blfv_pkg::CFG_BETA_Z: beta_q[2] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // engine datapath
  always_ff @(posedge clk_i) begin
    wk_q    <= wk_d;
    rem_q   <= rem_d;
    opnd_q  <= opnd_d;
    prod_q  <= prod_d;
    b2_q    <= b2_d;
    gamma_q <= gamma_d;
  end

  // accept items only while the matrix is settled
  assign in_i.ready       = (state_q == ST_IDLE) && !full_i;
  assign push_o           = in_i.valid && in_i.ready;
  assign push_item_o.data = in_i.payload;
  assign push_item_o.bad  = coef_q.bad;
  assign coef_o           = coef_q;

endmodule

>>> rtl/core/blfv_fifo.sv
// ----------------------------------------------------------------------------
// blfv_fifo
// Short item queue between the accepting front and the arithmetic back.
// ----------------------------------------------------------------------------
module blfv_fifo #(
  parameter int unsigned Depth = blfv_pkg::FifoDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  blfv_pkg::queue_item_t push_item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output blfv_pkg::queue_item_t pop_item_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW = $clog2(Depth + 1);

  blfv_pkg::queue_item_t mem_q [Depth];
  logic [AW-1:0]         wr_q, rd_q;
  logic [NW-1:0]         cnt_q;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o     = cnt_q == NW'(Depth);
  assign valid_o    = cnt_q != '0;
  assign pop_item_o = mem_q[rd_q];

  // store pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= wrap_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && pop_i) |=> cnt_q == $past(cnt_q)) else $error("count moved on push and pop");
`endif

endmodule

>>> rtl/core/blfv_back.sv
// ----------------------------------------------------------------------------
// blfv_back
// Multiplies both four-vectors of each queued item by the boost matrix:
// split partial products, pairwise sums, then rounding, saturation and
// the output register.
// ----------------------------------------------------------------------------
module blfv_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  input  blfv_pkg::queue_item_t pop_item_i,
  output logic                  pop_o,
  input  blfv_pkg::coef_t       coef_i,
  blfv_stream_if.source         out_o
);

  logic v1_q, v2_q, v3_q;
  logic bad1_q, bad2_q;
  logic en1, en2, en3;

  logic signed [63:0] plo_q  [2][4][4];
  logic signed [62:0] phi_q  [2][4][4];
  logic signed [95:0] part_q [2][4][2];
  logic [31:0]        row_res [2][4];

  blfv_pkg::out_item_t out_q, out_d;

  function automatic logic signed [blfv_pkg::CoefW-1:0] coef_at(
    input blfv_pkg::coef_t c,
    input logic [1:0]      r,
    input logic [1:0]      k
  );
    case ({r, k})
      4'b0000:          return c.l00;
      4'b0001, 4'b0100: return c.l01;
      4'b0010, 4'b1000: return c.l02;
      4'b0011, 4'b1100: return c.l03;
      4'b0101:          return c.l11;
      4'b1010:          return c.l22;
      4'b1111:          return c.l33;
      4'b0110, 4'b1001: return c.l12;
      4'b0111, 4'b1101: return c.l13;
      default:          return c.l23;
    endcase
  endfunction

  function automatic logic signed [31:0] vec_at(
    input blfv_pkg::in_item_t d,
    input logic               s,
    input logic [1:0]         k
  );
    case ({s, k})
      3'b000:  return d.time_in;
      3'b001:  return d.pos_x_in;
      3'b010:  return d.pos_y_in;
      3'b011:  return d.pos_z_in;
      3'b100:  return d.energy_in;
      3'b101:  return d.mom_x_in;
      3'b110:  return d.mom_y_in;
      default: return d.mom_z_in;
    endcase
  endfunction

  function automatic logic [31:0] round_sat(input logic signed [95:0] acc);
    logic signed [95:0] rnd;
    rnd = acc + $signed({32'd0, blfv_pkg::HalfQ29});
    if (rnd[95:61] == {35{rnd[95]}}) return rnd[61:30];
    else if (rnd[95]) return blfv_pkg::SatMin;
    else return blfv_pkg::SatMax;
  endfunction

  // advance each stage when the one after it frees up
  assign en3   = !v3_q || out_o.ready;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign pop_o = pop_valid_i && en1;

  for (genvar s = 0; s < 2; s++) begin : g_vec
    for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar k = 0; k < 4; k++) begin : g_term
        logic signed [blfv_pkg::CoefW-1:0] cf;
        logic signed [31:0]                vv;
        logic signed [31:0]                clo;
        logic signed [30:0]                chi;
        assign cf  = coef_at(coef_i, 2'(r), 2'(k));
        assign vv  = vec_at(pop_item_i.data, 1'(s), 2'(k));
        assign clo = $signed({1'b0, cf[30:0]});
        assign chi = cf[61:31];
        // split the coefficient into two 31-bit halves
        always_ff @(posedge clk_i) begin
          if (en1) begin
            plo_q[s][r][k] <= vv * clo;
            phi_q[s][r][k] <= vv * chi;
          end
        end
      end

      logic signed [95:0] full_p [4];
      for (genvar k = 0; k < 4; k++) begin : g_join
        assign full_p[k] = $signed({{2{phi_q[s][r][k][62]}}, phi_q[s][r][k], 31'd0}) +
                           $signed({{32{plo_q[s][r][k][63]}}, plo_q[s][r][k]});
      end

      // pairwise sums of the four terms
      always_ff @(posedge clk_i) begin
        if (en2) begin
          part_q[s][r][0] <= full_p[0] + full_p[1];
          part_q[s][r][1] <= full_p[2] + full_p[3];
        end
      end

      assign row_res[s][r] = round_sat(part_q[s][r][0] + part_q[s][r][1]);
    end
  end

  // map rows to result fields
  always_comb begin
    out_d.time_out   = row_res[0][0];
    out_d.pos_x_out  = row_res[0][1];
    out_d.pos_y_out  = row_res[0][2];
    out_d.pos_z_out  = row_res[0][3];
    out_d.energy_out = row_res[1][0];
    out_d.mom_x_out  = row_res[1][1];
    out_d.mom_y_out  = row_res[1][2];
    out_d.mom_z_out  = row_res[1][3];
    out_d.bad_speed  = bad2_q;
  end

  // tags and output register
  always_ff @(posedge clk_i) begin
    if (en1) begin
      bad1_q <= pop_item_i.bad;
    end
    if (en2) begin
      bad2_q <= bad1_q;
    end
    if (en3) begin
      out_q <= out_d;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pop_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  assign out_o.valid   = v3_q;
  assign out_o.payload = out_q;

endmodule

>>> rtl/core/lorentz_boost_four_vectors.sv
// ----------------------------------------------------------------------------
// lorentz_boost_four_vectors
// General Lorentz boost of space-time and energy-momentum four-vectors by a
// configured velocity.
//
//   channel  direction  handshake        payload
//   in_i     sink       valid/ready      eight Q16.16 vector components
//   out_o    source     valid/ready      eight boosted components, bad_speed
//   cfg      write      cfg_we_i         cfg_idx_i selects beta_x/y/z
//
// One item per cycle while in_i.ready is high; each taken item passes the
// queue write, partial products, pairwise sums and the rounding register.
// After a register write the serial coefficient engine holds in_i.ready low
// while it squares the velocity and, unless the boost is slow or impossible,
// runs a 32-step root, then divides and further multiplies in turn.
// After reset the matrix is the identity and items are taken at once.
// A stalled output fills the pipeline and the queue, then drops ready.
// ----------------------------------------------------------------------------
module lorentz_boost_four_vectors #(
  parameter int unsigned FifoDepth = blfv_pkg::FifoDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [blfv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [blfv_pkg::BetaW-1:0]   cfg_wdata_i,
  blfv_stream_if.sink                  in_i,
  blfv_stream_if.source                out_o
);

  logic                  push, full, pop, q_valid;
  blfv_pkg::queue_item_t push_item, pop_item;
  blfv_pkg::coef_t       coef;

  // accept, tag and derive the matrix
  blfv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item),
    .coef_o      (coef)
  );

  // decouple front and back
  blfv_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // matrix-vector arithmetic
  blfv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .coef_i      (coef),
    .out_o       (out_o)
  );

endmodule
